/* design/run_length_pattern_matcher_assert.svh */
// Assertion macros shared by the run-length pattern matcher modules.
// No dependencies; include with the bare file name inside a module.
`ifndef RUN_LENGTH_PATTERN_MATCHER_ASSERT_SVH
`define RUN_LENGTH_PATTERN_MATCHER_ASSERT_SVH

// same-cycle implication
`define RLPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlpm: same-cycle check failed");

// next-cycle implication
`define RLPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlpm: next-cycle check failed");

`endif

/* design/rlpm_pkg.sv */
// Shared types and constants for the run-length pattern matcher.
// No dependencies.
package rlpm_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int PLEN_BITS       = 5;
   localparam int PAT_ENTRIES     = 16;
   localparam int PAT_IDX_BITS    = 4;
   localparam int PAT_ENTRY_BITS  = 16;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int MATCH_ADDR_BITS = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH  = 3'd0,
      CSR_PATTERN_WORDS_0 = 3'd1,
      CSR_PATTERN_WORDS_1 = 3'd2,
      CSR_PATTERN_WORDS_2 = 3'd3,
      CSR_PATTERN_WORDS_3 = 3'd4
   } csr_index_type;

   typedef logic [PAT_ENTRIES-1:0][PAT_ENTRY_BITS-1:0] pattern_type;

   typedef struct packed {
      logic [PLEN_BITS-1:0] pattern_length;
      pattern_type          pattern;
   } cfg_type;

   typedef struct packed {
      logic last_close;   // last run close caused by this input word
      logic flush;        // end of stream: empty the window afterwards
   } close_flags_type;

   typedef struct packed {
      logic [MATCH_ADDR_BITS-1:0] match_address;
      logic                       last_result;
   } result_type;

   function automatic logic [PAT_ENTRY_BITS-1:0] pat_entry(pattern_type pat,
                                                           logic [31:0] idx);
      logic [PAT_ENTRY_BITS-1:0] val;
      if (idx >= 32'(PAT_ENTRIES)) begin
         val = '0;
      end else begin
         val = pat[idx[PAT_IDX_BITS-1:0]];
      end
      return val;
   endfunction

endpackage

/* design/rlpm_req_if.sv */
// Input word channel: valid/ready handshake with one data byte and end flag.
// Depends on rlpm_pkg.
interface rlpm_req_if import rlpm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_stream;

   modport source (output valid, data_byte, end_of_stream, input ready);
   modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

/* design/rlpm_rsp_if.sv */
// Result word channel: valid/ready handshake with match address and last flag.
// Depends on rlpm_pkg.
interface rlpm_rsp_if import rlpm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [MATCH_ADDR_BITS-1:0] match_address;
   logic                       last_result;

   modport source (output valid, match_address, last_result, input ready);
   modport sink   (input valid, match_address, last_result, output ready);
endinterface

/* design/rlpm_front.sv */
// Front end: tracks the open run, closes runs and pushes them to the close queue.
// Depends on rlpm_pkg, rlpm_req_if and the assertion macro header.
`include "run_length_pattern_matcher_assert.svh"
module rlpm_front import rlpm_pkg::*; #(
   parameter int RUN_BITS  = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   rlpm_req_if.sink             req_ch,
   output logic                 ev_valid,
   input  logic                 ev_ready,
   output logic [RUN_BITS-1:0]  ev_len,
   output logic [ADDR_BITS-1:0] ev_start,
   output close_flags_type      ev_flags
);

   logic [BYTE_BITS-1:0] run_byte_ff, run_byte_in;
   logic [RUN_BITS-1:0]  run_count_ff, run_count_in;
   logic [ADDR_BITS-1:0] run_start_ff, run_start_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 eos_pend_ff, eos_pend_in;
   logic [RUN_BITS-1:0]  cnt_inc;
   logic                 same;
   logic                 acc;

   assign req_ch.ready = !eos_pend_ff && ev_ready;
   assign acc          = req_ch.valid && req_ch.ready;
   assign same         = (run_count_ff != '0) && (req_ch.data_byte == run_byte_ff);
   assign cnt_inc      = (run_count_ff == '1) ? run_count_ff
                                              : run_count_ff + RUN_BITS'(1);

   always_comb begin
      run_byte_in  = run_byte_ff;
      run_count_in = run_count_ff;
      run_start_in = run_start_ff;
      addr_in      = addr_ff;
      eos_pend_in  = eos_pend_ff;
      ev_valid     = 1'b0;
      ev_len       = run_count_ff;
      ev_start     = run_start_ff;
      ev_flags     = '{last_close: 1'b1, flush: 1'b0};
      if (eos_pend_ff) begin
         ev_valid = 1'b1;
         ev_flags = '{last_close: 1'b1, flush: 1'b1};
         if (ev_ready) begin
            run_byte_in  = '0;
            run_count_in = '0;
            run_start_in = '0;
            addr_in      = '0;
            eos_pend_in  = 1'b0;
         end
      end else if (acc) begin
         addr_in = addr_ff + ADDR_BITS'(1);
         if (same) begin
            run_count_in = cnt_inc;
            if (req_ch.end_of_stream) begin
               ev_valid     = 1'b1;
               ev_len       = cnt_inc;
               ev_flags     = '{last_close: 1'b1, flush: 1'b1};
               run_byte_in  = '0;
               run_count_in = '0;
               run_start_in = '0;
               addr_in      = '0;
            end
         end else begin
            run_byte_in  = req_ch.data_byte;
            run_count_in = RUN_BITS'(1);
            run_start_in = addr_ff;
            if (run_count_ff != '0) begin
               ev_valid    = 1'b1;
               ev_flags    = '{last_close: !req_ch.end_of_stream, flush: 1'b0};
               eos_pend_in = req_ch.end_of_stream;
            end else if (req_ch.end_of_stream) begin
               ev_valid     = 1'b1;
               ev_len       = RUN_BITS'(1);
               ev_start     = addr_ff;
               ev_flags     = '{last_close: 1'b1, flush: 1'b1};
               run_byte_in  = '0;
               run_count_in = '0;
               run_start_in = '0;
               addr_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_byte_ff  <= '0;
         run_count_ff <= '0;
         run_start_ff <= '0;
         addr_ff      <= '0;
         eos_pend_ff  <= 1'b0;
      end else begin
         run_byte_ff  <= run_byte_in;
         run_count_ff <= run_count_in;
         run_start_ff <= run_start_in;
         addr_ff      <= addr_in;
         eos_pend_ff  <= eos_pend_in;
      end
   end

   `RLPM_ASSERT_NEXT(a_eos_clears, clock, reset, acc && req_ch.end_of_stream, (run_count_ff == '0) || eos_pend_ff)
   `RLPM_ASSERT_IMP(a_pend_single, clock, reset, eos_pend_ff, run_count_ff == RUN_BITS'(1))
   `RLPM_ASSERT_NEXT(a_pend_drains, clock, reset, eos_pend_ff && ev_ready, !eos_pend_ff && (addr_ff == '0))

endmodule

/* design/rlpm_queue.sv */
// Two-word queue carrying closed runs from the front end to the back end.
// Depends on rlpm_pkg.
module rlpm_queue import rlpm_pkg::*; #(
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0]          data_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      push, pop;

   assign in_ready  = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

/* design/rlpm_back.sv */
// Back end: run-length window, parallel pattern compare and two-slot result buffer.
// Depends on rlpm_pkg, rlpm_rsp_if and the assertion macro header.
`include "run_length_pattern_matcher_assert.svh"
module rlpm_back import rlpm_pkg::*; #(
   parameter int PATTERN_MAX = 16,
   parameter int RUN_BITS    = 16,
   parameter int ADDR_BITS   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 ev_valid,
   output logic                 ev_ready,
   input  logic [RUN_BITS-1:0]  ev_len,
   input  logic [ADDR_BITS-1:0] ev_start,
   input  close_flags_type      ev_flags,
   rlpm_rsp_if.source           rsp_ch
);

   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CMP_BITS = (RUN_BITS > PAT_ENTRY_BITS) ? RUN_BITS : PAT_ENTRY_BITS;

   logic [RUN_BITS-1:0]       win_len_ff   [PATTERN_MAX];
   logic [ADDR_BITS-1:0]      win_start_ff [PATTERN_MAX];
   logic [LEN_BITS-1:0]       fill_ff, fill_in;
   logic [RUN_BITS-1:0]       sh_len       [PATTERN_MAX];
   logic [ADDR_BITS-1:0]      sh_start     [PATTERN_MAX];
   logic [PAT_ENTRY_BITS-1:0] pat_sel      [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]    eq;
   logic [LEN_BITS-1:0]       fill_new;
   logic [LEN_BITS-1:0]       plen;
   logic [IDX_BITS-1:0]       sel;
   logic                      match;
   logic [MATCH_ADDR_BITS-1:0] match_addr;

   logic                       pend_valid_ff, pend_valid_in;
   logic [MATCH_ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;

   result_type slot_ff [2];
   result_type slot_in [2];
   logic [1:0] o_cnt_ff, o_cnt_in;
   logic [1:0] cnt_rem;
   logic [1:0] free;
   logic [1:0] n_push;
   logic       pop;
   logic       ev_do;
   result_type res_a, res_b;

   // window after shifting in the closed run
   always_comb begin
      sh_len[0]   = ev_len;
      sh_start[0] = ev_start;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         sh_len[i]   = win_len_ff[i-1];
         sh_start[i] = win_start_ff[i-1];
      end
   end

   assign plen     = (32'(cfg.pattern_length) > 32'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                                 : LEN_BITS'(cfg.pattern_length);
   assign fill_new = (fill_ff == LEN_BITS'(PATTERN_MAX)) ? fill_ff : fill_ff + LEN_BITS'(1);
   assign sel      = IDX_BITS'(plen - LEN_BITS'(1));

   // window entry j meets pattern entry plen-1-j
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_sel[j] = pat_entry(cfg.pattern, 32'(plen) - 32'(j) - 32'd1);
         eq[j]      = (j >= int'(plen)) ||
                      (CMP_BITS'(sh_len[j]) == CMP_BITS'(pat_sel[j]));
      end
   end

   assign match      = (plen != '0) && (fill_new >= plen) && (&eq);
   assign match_addr = MATCH_ADDR_BITS'(sh_start[sel]);

   // result buffer bookkeeping
   assign pop     = (o_cnt_ff != 2'd0) && rsp_ch.ready;
   assign cnt_rem = o_cnt_ff - {1'b0, pop};
   assign free    = 2'd2 - cnt_rem;

   always_comb begin
      n_push = 2'd0;
      res_a  = '{match_address: match_addr, last_result: 1'b1};
      res_b  = '{match_address: match_addr, last_result: 1'b1};
      if (ev_flags.last_close) begin
         if (pend_valid_ff) begin
            n_push = match ? 2'd2 : 2'd1;
            res_a  = '{match_address: pend_addr_ff, last_result: !match};
         end else begin
            n_push = {1'b0, match};
         end
      end
   end

   assign ev_ready = (n_push <= free);
   assign ev_do    = ev_valid && ev_ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      fill_in       = fill_ff;
      if (ev_do) begin
         fill_in = ev_flags.flush ? '0 : fill_new;
         if (ev_flags.last_close) begin
            pend_valid_in = 1'b0;
         end else if (match) begin
            pend_valid_in = 1'b1;
            pend_addr_in  = match_addr;
         end
      end
   end

   always_comb begin
      slot_in[0] = (cnt_rem != 2'd0) ? (pop ? slot_ff[1] : slot_ff[0]) : res_a;
      slot_in[1] = (cnt_rem == 2'd2) ? slot_ff[1] :
                   (cnt_rem == 2'd1) ? res_a : res_b;
      o_cnt_in   = cnt_rem + (ev_do ? n_push : 2'd0);
   end

   assign rsp_ch.valid         = (o_cnt_ff != 2'd0);
   assign rsp_ch.match_address = slot_ff[0].match_address;
   assign rsp_ch.last_result   = slot_ff[0].last_result;

   always_ff @(posedge clock) begin
      if (ev_do) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_len_ff[i]   <= sh_len[i];
            win_start_ff[i] <= sh_start[i];
         end
      end
      pend_addr_ff <= pend_addr_in;
      slot_ff[0]   <= slot_in[0];
      slot_ff[1]   <= slot_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         o_cnt_ff      <= 2'd0;
      end else begin
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         o_cnt_ff      <= o_cnt_in;
      end
   end

   `RLPM_ASSERT_IMP(a_out_bound, clock, reset, 1'b1, o_cnt_ff <= 2'd2)
   `RLPM_ASSERT_IMP(a_pend_pairs, clock, reset, pend_valid_ff && ev_do, ev_flags.last_close)
   `RLPM_ASSERT_NEXT(a_pend_set, clock, reset, ev_do && !ev_flags.last_close && match, pend_valid_ff)

endmodule

/* design/run_length_pattern_matcher.sv */
// Top level of the run-length pattern matcher: control registers and wiring.
// Depends on rlpm_pkg, rlpm_req_if, rlpm_rsp_if, rlpm_front, rlpm_queue, rlpm_back.
//
//   channel  dir  handshake       payload
//   req_ch   in   valid/ready     data_byte[7:0], end_of_stream
//   rsp_ch   out  valid/ready     match_address[31:0], last_result
//   csr_*    in   csr_wr_en only  csr_index[2:0], csr_wr_data[63:0]
//
// One byte per cycle while the close queue has room; an end-of-stream byte that also
// closes the previous run stalls req_ch until the front end, pushing one run close
// per cycle into the queue, has pushed both. A match passes the close queue and the
// result buffer registers on its way to rsp_ch.
// Reset is synchronous; no clearing pass, the window is tracked by a fill count.
// req_ch stalls when the two-word close queue is full; the back end stalls a
// close whose results do not fit in the two-slot result buffer.
module run_length_pattern_matcher import rlpm_pkg::*; #(
   parameter int PATTERN_MAX = 16,
   parameter int RUN_BITS    = 16,
   parameter int ADDR_BITS   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   rlpm_req_if.sink                  req_ch,
   rlpm_rsp_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int FLAG_BITS = $bits(close_flags_type);
   localparam int EV_BITS   = FLAG_BITS + ADDR_BITS + RUN_BITS;

   cfg_type cfg_ff, cfg_in;

   logic                 f_valid, f_ready;
   logic [RUN_BITS-1:0]  f_len;
   logic [ADDR_BITS-1:0] f_start;
   close_flags_type      f_flags;

   logic                 b_valid, b_ready;
   logic [EV_BITS-1:0]   b_data;
   logic [RUN_BITS-1:0]  b_len;
   logic [ADDR_BITS-1:0] b_start;
   close_flags_type      b_flags;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:  cfg_in.pattern_length = csr_wr_data[PLEN_BITS-1:0];
            CSR_PATTERN_WORDS_0: cfg_in.pattern[0 +: 4]  = csr_wr_data;
            CSR_PATTERN_WORDS_1: cfg_in.pattern[4 +: 4]  = csr_wr_data;
            CSR_PATTERN_WORDS_2: cfg_in.pattern[8 +: 4]  = csr_wr_data;
            CSR_PATTERN_WORDS_3: cfg_in.pattern[12 +: 4] = csr_wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_length <= PLEN_BITS'(1);
         cfg_ff.pattern        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlpm_front #(
      .RUN_BITS  (RUN_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .ev_valid (f_valid),
      .ev_ready (f_ready),
      .ev_len   (f_len),
      .ev_start (f_start),
      .ev_flags (f_flags)
   );

   rlpm_queue #(
      .WIDTH (EV_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_flags, f_start, f_len}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   assign b_len   = b_data[RUN_BITS-1:0];
   assign b_start = b_data[RUN_BITS +: ADDR_BITS];
   assign b_flags = b_data[EV_BITS-1 -: FLAG_BITS];

   rlpm_back #(
      .PATTERN_MAX (PATTERN_MAX),
      .RUN_BITS    (RUN_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ev_valid (b_valid),
      .ev_ready (b_ready),
      .ev_len   (b_len),
      .ev_start (b_start),
      .ev_flags (b_flags),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* tb/sv/rlpm_match_checker.sv */
`timescale 1ns / 100ps
// Match checker for the run-length pattern matcher bench: follows register writes and
// accepted input words, predicts the match results and compares each accepted one.
// Depends on rlpm_pkg, rlpm_req_if and rlpm_rsp_if.
module rlpm_match_checker import rlpm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   rlpm_req_if                       req_ch,
   rlpm_rsp_if                       rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        checked
);

   localparam logic [PAT_ENTRY_BITS-1:0] RUN_SAT = '1;

   logic [PLEN_BITS-1:0]                  cfg_len;
   logic [PAT_ENTRIES*PAT_ENTRY_BITS-1:0] cfg_pat;

   logic [BYTE_BITS-1:0]       run_val;
   logic [PAT_ENTRY_BITS-1:0]  run_len;
   logic [MATCH_ADDR_BITS-1:0] run_addr;
   logic [MATCH_ADDR_BITS-1:0] next_addr;
   logic [PAT_ENTRY_BITS-1:0]  hist_len  [PAT_ENTRIES];
   logic [MATCH_ADDR_BITS-1:0] hist_addr [PAT_ENTRIES];
   int                         hist_fill;

   result_type expected_matches [$];

   function automatic void clear_stream();
      run_val   = '0;
      run_len   = '0;
      run_addr  = '0;
      next_addr = '0;
      hist_fill = 0;
      for (int i = 0; i < PAT_ENTRIES; i++) begin
         hist_len[i]  = '0;
         hist_addr[i] = '0;
      end
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_PATTERN_LENGTH:  cfg_len = data[PLEN_BITS-1:0];
         CSR_PATTERN_WORDS_0: cfg_pat[0*CSR_DATA_BITS +: CSR_DATA_BITS] = data;
         CSR_PATTERN_WORDS_1: cfg_pat[1*CSR_DATA_BITS +: CSR_DATA_BITS] = data;
         CSR_PATTERN_WORDS_2: cfg_pat[2*CSR_DATA_BITS +: CSR_DATA_BITS] = data;
         CSR_PATTERN_WORDS_3: cfg_pat[3*CSR_DATA_BITS +: CSR_DATA_BITS] = data;
         default: ;
      endcase
   endfunction

   // shifts the open run into the history and tests the newest runs against the pattern
   function automatic bit close_run(output logic [MATCH_ADDR_BITS-1:0] addr);
      int n;
      bit hit;
      addr = '0;
      if (run_len == 0) return 1'b0;
      for (int i = PAT_ENTRIES - 1; i > 0; i--) begin
         hist_len[i]  = hist_len[i-1];
         hist_addr[i] = hist_addr[i-1];
      end
      hist_len[0]  = run_len;
      hist_addr[0] = run_addr;
      if (hist_fill < PAT_ENTRIES) hist_fill++;
      run_len = '0;
      n = (cfg_len > PAT_ENTRIES) ? PAT_ENTRIES : int'(cfg_len);
      if (n == 0 || hist_fill < n) return 1'b0;
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (hist_len[n-1-i] != cfg_pat[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS]) hit = 1'b0;
      end
      if (hit) addr = hist_addr[n-1];
      return hit;
   endfunction

   function automatic void take_word(logic [BYTE_BITS-1:0] b, logic eos);
      logic [MATCH_ADDR_BITS-1:0] addr;
      result_type r;
      int n0;
      n0 = expected_matches.size();
      r.last_result = 1'b0;
      if (run_len != 0 && b == run_val) begin
         if (run_len != RUN_SAT) run_len++;
      end else begin
         if (close_run(addr)) begin
            r.match_address = addr;
            expected_matches.insert(expected_matches.size(), r);
         end
         run_val  = b;
         run_len  = PAT_ENTRY_BITS'(1);
         run_addr = next_addr;
      end
      next_addr++;
      if (eos) begin
         if (close_run(addr)) begin
            r.match_address = addr;
            expected_matches.insert(expected_matches.size(), r);
         end
         clear_stream();
      end
      if (expected_matches.size() > n0)
         expected_matches[expected_matches.size()-1].last_result = 1'b1;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_len = PLEN_BITS'(1);
         cfg_pat = '0;
         clear_stream();
         expected_matches.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got address %h last %b",
                        $time, rsp_ch.match_address, rsp_ch.last_result);
               fail_count++;
            end else begin
               want = expected_matches.pop_front();
               checked++;
               if (rsp_ch.match_address !== want.match_address) begin
                  $display("%0t: match_address expected %h, got %h",
                           $time, want.match_address, rsp_ch.match_address);
                  fail_count++;
               end
               if (rsp_ch.last_result !== want.last_result) begin
                  $display("%0t: last_result expected %b, got %b",
                           $time, want.last_result, rsp_ch.last_result);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) apply_csr(csr_index, csr_wr_data);
         if (req_ch.valid && req_ch.ready) take_word(req_ch.data_byte, req_ch.end_of_stream);
      end
      pending = expected_matches.size();
   end

endmodule

/* tb/sv/tb_run_length_pattern_matcher.sv */
`timescale 1ns / 100ps
// Top of the run-length pattern matcher bench: clock, reset, register writes, byte
// streams and result back-pressure; rlpm_match_checker does all the checking.
// Depends on rlpm_pkg, rlpm_req_if, rlpm_rsp_if, rlpm_match_checker and the design.
module tb_run_length_pattern_matcher;
   import rlpm_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 1800;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;

   rlpm_req_if req_ch ();
   rlpm_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int checked;

   bit tx_gaps;
   bit rx_stalls;
   int words_sent;
   int streams_sent;
   int settings_used;
   int pat_n;
   logic [PAT_ENTRIES*PAT_ENTRY_BITS-1:0] pat_bits;

   run_length_pattern_matcher uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rlpm_match_checker match_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("%0t: run timed out", $time);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // a fresh run byte, now and then equal to the last one so that runs merge
   function automatic logic [BYTE_BITS-1:0] next_run_byte(logic [BYTE_BITS-1:0] prev);
      logic [BYTE_BITS-1:0] b;
      b = BYTE_BITS'($urandom);
      if ($urandom_range(0, 99) < 6) b = prev;
      else if (b == prev) b = ~prev;
      return b;
   endfunction

   initial begin : rsp_sink
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = rx_stalls ? pick_gap() : 0;
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_word(input logic [BYTE_BITS-1:0] b, input logic eos);
      int gap;
      gap = tx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= b;
      req_ch.end_of_stream <= eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // stop sending and wait for every outstanding match, then a few spare cycles
   task automatic settle(input int extra);
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic program_pattern(input logic [PLEN_BITS-1:0] len,
                                  input logic [PAT_ENTRIES*PAT_ENTRY_BITS-1:0] bits);
      settle(SETTLE_CYCLES);
      write_reg(CSR_PATTERN_LENGTH, CSR_DATA_BITS'(len));
      write_reg(CSR_PATTERN_WORDS_0, bits[0*CSR_DATA_BITS +: CSR_DATA_BITS]);
      write_reg(CSR_PATTERN_WORDS_1, bits[1*CSR_DATA_BITS +: CSR_DATA_BITS]);
      write_reg(CSR_PATTERN_WORDS_2, bits[2*CSR_DATA_BITS +: CSR_DATA_BITS]);
      write_reg(CSR_PATTERN_WORDS_3, bits[3*CSR_DATA_BITS +: CSR_DATA_BITS]);
      csr_wr_en <= 1'b0;
      pat_bits = bits;
      pat_n    = (len > PAT_ENTRIES) ? PAT_ENTRIES : int'(len);
      settings_used++;
   endtask

   // runs of random length, with copies of the pattern spliced in when every entry is 1 to 8
   task automatic send_stream(input int target, input bit terminate);
      logic [BYTE_BITS-1:0] seq [$];
      logic [BYTE_BITS-1:0] b;
      logic [PAT_ENTRY_BITS-1:0] entry;
      bit fits;
      int r;
      int run;
      b = BYTE_BITS'($urandom);
      fits = (pat_n > 0);
      for (int i = 0; i < pat_n; i++) begin
         entry = pat_bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS];
         if (entry == 0 || entry > 8) fits = 1'b0;
      end
      while (seq.size() < target) begin
         if (fits && $urandom_range(0, 99) < 35) begin
            for (int i = 0; i < pat_n; i++) begin
               b = next_run_byte(b);
               repeat (pat_bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS]) seq.insert(seq.size(), b);
            end
         end else begin
            b = next_run_byte(b);
            r = $urandom_range(0, 99);
            run = (r < 60) ? $urandom_range(1, 3) :
                  (r < 92) ? $urandom_range(4, 8) : $urandom_range(9, 40);
            repeat (run) seq.insert(seq.size(), b);
         end
      end
      foreach (seq[i]) send_word(seq[i], terminate && (i == seq.size() - 1));
      streams_sent++;
   endtask

   task automatic random_phase(input int phase_no);
      logic [PLEN_BITS-1:0] len;
      logic [PAT_ENTRIES*PAT_ENTRY_BITS-1:0] bits;
      int r;
      int n;
      int streams;
      int target;
      bit tame;
      r = $urandom_range(0, 99);
      if (r < 8) len = '0;
      else if (r < 20) len = PLEN_BITS'(1);
      else if (r < 35) len = PLEN_BITS'(PAT_ENTRIES);
      else if (r < 45) len = PLEN_BITS'($urandom_range(17, 31));
      else len = PLEN_BITS'($urandom_range(2, 15));
      n = (len > PAT_ENTRIES) ? PAT_ENTRIES : int'(len);
      tame = ($urandom_range(0, 99) < 75);
      for (int i = 0; i < PAT_ENTRIES; i++) begin
         r = $urandom_range(0, 3);
         if (i >= n)
            bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS] = PAT_ENTRY_BITS'($urandom);
         else if (tame || r == 0)
            bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS] = PAT_ENTRY_BITS'($urandom_range(1, 4));
         else if (r == 1) bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS] = '1;
         else if (r == 2) bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS] = '0;
         else bits[i*PAT_ENTRY_BITS +: PAT_ENTRY_BITS] = PAT_ENTRY_BITS'($urandom);
      end
      program_pattern(len, bits);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      streams = $urandom_range(1, 4);
      for (int s = 0; s < streams; s++) begin
         r = $urandom_range(0, 99);
         target = (r < 10) ? 1 : (r < 85) ? $urandom_range(4, 40) : $urandom_range(41, 150);
         // last stream of a setting is sometimes left open across the register writes
         send_stream(target, (s < streams - 1) || ($urandom_range(0, 3) != 0));
         if (phase_no == 2 && s == 0) settle(0);
      end
   endtask

   initial begin : stimulus
      int start_words;
      int phase_no;
      int waited;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_PATTERN_LENGTH;
      csr_wr_data          <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.data_byte     <= '0;
      req_ch.end_of_stream <= 1'b0;
      tx_gaps       = 1'b0;
      rx_stalls     = 1'b1;
      words_sent    = 0;
      streams_sent  = 0;
      settings_used = 0;
      pat_n         = 1;
      pat_bits      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out-of-range index must leave the reset pattern alone: no matches here
      write_reg(CSR_UNUSED, 64'h0001_0001_0001_0001);
      csr_wr_en <= 1'b0;
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b1);

      // single-byte runs match; one word closes two runs; one-word stream
      program_pattern(5'd1, {240'h0, 16'h0001});
      send_word(8'h11, 1'b0);
      send_word(8'h22, 1'b1);
      send_word(8'h80, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hA5, 1'b1);

      // zero pattern length never matches
      program_pattern(5'd0, '1);
      send_word(8'h01, 1'b0);
      send_word(8'h02, 1'b0);
      send_word(8'h03, 1'b1);

      // oversized length clamps to the full window; too few runs to match
      program_pattern(5'd31, {PAT_ENTRIES{16'h0001}});
      send_word(8'h40, 1'b0);
      send_word(8'h41, 1'b0);
      send_word(8'h42, 1'b0);
      send_word(8'h43, 1'b1);

      program_pattern(5'd2, {224'h0, 16'h0001, 16'h0002});
      send_word(8'h7F, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h81, 1'b1);

      start_words = words_sent;
      phase_no = 0;
      while (words_sent - start_words < RANDOM_WORDS) begin
         random_phase(phase_no);
         phase_no++;
      end

      req_ch.valid <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (pending != 0 && waited < 20000);
      repeat (16) @(posedge clock);
      @(negedge clock);
      if (pending != 0)
         $display("%0t: %0d expected match word(s) never arrived", $time, pending);
      $display("Sent %0d words in %0d streams over %0d pattern settings,", words_sent,
               streams_sent, settings_used);
      $display("compared %0d match words under random gaps and result stalls.", checked);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
